/* src/lsau_pkg.sv */
// ----------------------------------------------------------------------------
// Load/store address unit package
// Shared transaction types, command and status codes, and the offset shifter.
// ----------------------------------------------------------------------------
package lsau_pkg;

  localparam int unsigned NumRegs  = 16;
  localparam int unsigned RegAddrW = 4;
  localparam int unsigned DataW    = 32;

  // Command codes
  localparam logic [1:0] CMD_WRITE_REG = 2'd0;
  localparam logic [1:0] CMD_EXECUTE   = 2'd1;
  localparam logic [1:0] CMD_LOAD_RET  = 2'd2;
  localparam logic [1:0] CMD_UNUSED    = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  // Shift types
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_MEM_SIZE = 2'd0;
  localparam logic [1:0] CFG_DEV_LOW  = 2'd1;
  localparam logic [1:0] CFG_DEV_HIGH = 2'd2;

  localparam logic [31:0] MEM_SIZE_RST = 32'h0001_0000;
  localparam logic [31:0] DEV_LOW_RST  = 32'h2020_0000;
  localparam logic [31:0] DEV_HIGH_RST = 32'h2020_0028;

  // Register that may not supply a shift amount
  localparam logic [3:0] REG_PC = 4'd15;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RS,
    S_RM,
    S_RN,
    S_RD,
    S_SUM,
    S_FIN
  } lsau_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic        immediate_form;
    logic        pre_index;
    logic        add_offset;
    logic        is_load;
    logic [3:0]  base_reg;
    logic [3:0]  data_reg;
    logic [11:0] offset_field;
    logic [3:0]  reg_index;
    logic [31:0] value;
  } lsau_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        request_valid;
    logic        request_is_load;
    logic [31:0] address;
    logic [31:0] store_data;
  } lsau_out_t;

  // Amount 0 is identity; LSL/LSR of 32 or more give zero, ASR saturates to
  // the sign, ROR uses the amount modulo 32.
  function automatic logic [31:0] shift_value(logic [31:0] v, logic [1:0] kind,
                                              logic [7:0] amt);
    logic [31:0] r;
    logic        big;
    logic [4:0]  a;
    a   = amt[4:0];
    big = |amt[7:5];
    r   = v;
    if (amt != 8'd0) begin
      case (kind)
        SH_LSL: r = big ? 32'd0 : (v << a);
        SH_LSR: r = big ? 32'd0 : (v >> a);
        SH_ASR: r = big ? {32{v[31]}} : unsigned'($signed(v) >>> a);
        SH_ROR: r = 32'({v, v} >> a);
        default: r = v;
      endcase
    end
    return r;
  endfunction

endpackage

/* src/lsau_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on the array.
// ----------------------------------------------------------------------------
module lsau_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/load_store_address_unit.sv */
// ----------------------------------------------------------------------------
// Load/store address unit
// Executes single data transfers against a 16 x 32 register file held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one command
//   per transaction: write register, execute transfer or load data return.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly
//   one result per input transaction, in order.
//   Config port (cfg_we_i / cfg_index_i / cfg_data_i) sets memory size and
//   the device window; write it only while the unit is idle.
// Sequencing:
//   Write-register, load-return and unused commands go from idle straight
//   to the final stage. Execute steps through four sequential reads of the
//   single read port of the register file RAM (shift register, offset
//   register, base, data), then a shift, an add and a range-check stage.
//   One transaction is in flight at a time.
// Reset:
//   Config registers take their defaults, pending load state clears, and a
//   16-bit valid vector marks every register as zero until first written.
// Stall:
//   The result waits in the output register; the unit keeps accepting the
//   next transaction and holds it in the final stage until the slot frees.
// ----------------------------------------------------------------------------
module load_store_address_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lsau_pkg::lsau_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lsau_pkg::lsau_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import lsau_pkg::*;

  // Control state
  lsau_state_e state_q, state_d;
  logic [NumRegs-1:0] vld_q, vld_d;
  logic rd_vld_q;
  logic [3:0] pend_dest_q, pend_dest_d;
  logic pend_drop_q, pend_drop_d;
  logic out_valid_q, out_valid_d;

  // Config
  logic [31:0] mem_size_q, dev_low_q, dev_high_q;

  // Datapath registers (no reset)
  lsau_in_t  item_q;
  lsau_out_t out_q, out_d;
  logic [7:0]  amount_q;
  logic [31:0] rm_val_q, base_q, offset_q, sd_q, sum_q;

  // RAM port
  logic        ram_we;
  logic [3:0]  ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata, rdata_eff;

  logic in_acc, fin_go;
  logic invalid, illegal;
  logic [31:0] addr;
  logic [7:0]  amount_sel;

  lsau_ram #(
    .Width(DataW),
    .Depth(NumRegs)
  ) u_regfile (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Never-written registers read as zero.
  assign rdata_eff = rd_vld_q ? ram_rdata : 32'd0;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign fin_go      = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Decode of the held transaction
  always_comb begin
    invalid = 1'b0;
    if (item_q.immediate_form) begin
      if (!item_q.pre_index && (item_q.base_reg == item_q.offset_field[3:0])) begin
        invalid = 1'b1;
      end
      if (item_q.offset_field[4]) begin
        if (item_q.offset_field[7] || (item_q.offset_field[11:8] == REG_PC)) begin
          invalid = 1'b1;
        end
      end
    end
  end

  assign amount_sel = item_q.offset_field[4] ? amount_q : {3'd0, item_q.offset_field[11:7]};
  assign addr       = item_q.pre_index ? sum_q : base_q;
  assign illegal    = (addr >= mem_size_q) && ((addr < dev_low_q) || (addr > dev_high_q));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (in_data_i.command == CMD_EXECUTE) ? S_RS : S_FIN;
        end
      end
      S_RS:  state_d = S_RM;
      S_RM:  state_d = S_RN;
      S_RN:  state_d = S_RD;
      S_RD:  state_d = S_SUM;
      S_SUM: state_d = S_FIN;
      S_FIN: begin
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of each state: RAM access, result, pending load and valid bits
  always_comb begin
    ram_raddr   = item_q.base_reg;
    ram_we      = 1'b0;
    ram_waddr   = item_q.reg_index;
    ram_wdata   = item_q.value;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pend_dest_d = pend_dest_q;
    pend_drop_d = pend_drop_q;
    vld_d       = vld_q;
    case (state_q)
      S_RS: ram_raddr = item_q.offset_field[11:8];
      S_RM: ram_raddr = item_q.offset_field[3:0];
      S_RN: ram_raddr = item_q.base_reg;
      S_RD: ram_raddr = item_q.data_reg;
      S_FIN: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status = ST_OK;
          case (item_q.command)
            CMD_WRITE_REG: begin
              ram_we = 1'b1;
            end
            CMD_LOAD_RET: begin
              ram_we    = !pend_drop_q;
              ram_waddr = pend_dest_q;
            end
            CMD_EXECUTE: begin
              if (invalid) begin
                out_d.status = ST_INVALID;
              end else if (illegal) begin
                out_d.status  = ST_ILLEGAL;
                out_d.address = addr;
              end else begin
                out_d.request_valid   = 1'b1;
                out_d.request_is_load = item_q.is_load;
                out_d.address         = addr;
                out_d.store_data      = item_q.is_load ? 32'd0 : sd_q;
                if (item_q.is_load) begin
                  pend_dest_d = item_q.data_reg;
                  pend_drop_d = !item_q.pre_index && (item_q.data_reg == item_q.base_reg);
                end
                // Post-indexed: write back base +/- offset
                ram_we    = !item_q.pre_index;
                ram_waddr = item_q.base_reg;
                ram_wdata = sum_q;
              end
            end
            default: out_d.status = ST_INVALID;
          endcase
          if (ram_we) begin
            vld_d[ram_waddr] = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      pend_dest_q <= '0;
      pend_drop_q <= 1'b0;
      out_valid_q <= 1'b0;
      mem_size_q  <= MEM_SIZE_RST;
      dev_low_q   <= DEV_LOW_RST;
      dev_high_q  <= DEV_HIGH_RST;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      rd_vld_q    <= vld_q[ram_raddr];
      pend_dest_q <= pend_dest_d;
      pend_drop_q <= pend_drop_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MEM_SIZE: mem_size_q <= cfg_data_i;
          CFG_DEV_LOW:  dev_low_q  <= cfg_data_i;
          CFG_DEV_HIGH: dev_high_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath: capture each read from the RAM's registered output in the following state
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_acc) begin
      item_q <= in_data_i;
    end
    case (state_q)
      S_RM: amount_q <= rdata_eff[7:0];
      S_RN: rm_val_q <= rdata_eff;
      S_RD: begin
        base_q   <= rdata_eff;
        offset_q <= item_q.immediate_form
                    ? shift_value(rm_val_q, item_q.offset_field[6:5], amount_sel)
                    : {20'd0, item_q.offset_field};
      end
      S_SUM: begin
        sd_q  <= rdata_eff;
        sum_q <= item_q.add_offset ? (base_q + offset_q) : (base_q - offset_q);
      end
      default: ;
    endcase
  end

  // Assertions
  a_exec_starts_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.command == CMD_EXECUTE) |=> state_q == S_RS)
    else $error("execute did not start the register read sequence");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result produced outside the final stage");

  a_write_in_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_FIN) && fin_go)
    else $error("register file written outside the final stage");

  a_request_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.request_valid |-> out_q.status == ST_OK)
    else $error("memory request issued with an error status");

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Load/store address unit testbench
// Drives write-register, execute, load-return and unused commands through the
// input channel under random idling and output stall, predicts every result
// with an independent model of the register file, shifter and range check,
// and compares each result field by field. Config sweeps cover the reset
// window, full-size memory, a full window, an empty window and random windows.
// ----------------------------------------------------------------------------
module testbench;
  import lsau_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;  // cycles with no transaction
  localparam int unsigned DrainCycles   = 12;    // margin over execute latency
  localparam int unsigned PhaseItems    = 125;
  localparam int unsigned NumPhases     = 6;

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own register file, pending load and window limits,
  // predicts the result of every accepted command and checks arrivals in order.
  // --------------------------------------------------------------------------
  class transfer_scoreboard;
    logic [31:0] regs [16];
    logic [3:0]  load_dest;
    logic        load_drop;
    logic [31:0] mem_size;
    logic [31:0] dev_lo;
    logic [31:0] dev_hi;
    lsau_out_t   expected_results [$];
    int unsigned errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      load_dest = '0;
      load_drop = 1'b0;
      mem_size  = MEM_SIZE_RST;
      dev_lo    = DEV_LOW_RST;
      dev_hi    = DEV_HIGH_RST;
      errors    = 0;
    endfunction

    function void set_limit(logic [1:0] idx, logic [31:0] v);
      case (idx)
        CFG_MEM_SIZE: mem_size = v;
        CFG_DEV_LOW:  dev_lo = v;
        CFG_DEV_HIGH: dev_hi = v;
        default: ;
      endcase
    endfunction

    // Zero amount is identity; LSL/LSR of 32+ clear, ASR of 32+ fills with
    // the sign, ROR wraps the amount modulo 32.
    function logic [31:0] shift_offset(logic [31:0] v, logic [1:0] kind, logic [7:0] amt);
      logic [63:0] wide;
      int unsigned n;
      if (amt == 8'd0) return v;
      case (kind)
        SH_LSL: return (amt >= 8'd32) ? 32'd0 : (v << amt);
        SH_LSR: return (amt >= 8'd32) ? 32'd0 : (v >> amt);
        SH_ASR: begin
          if (amt >= 8'd32) return {32{v[31]}};
          wide = {{32{v[31]}}, v};
          wide = wide >> amt;
          return wide[31:0];
        end
        default: begin
          n = amt % 32;
          if (n == 0) return v;
          return (v >> n) | (v << (32 - n));
        end
      endcase
    endfunction

    function lsau_out_t predict_transfer(lsau_in_t t);
      lsau_out_t   o;
      logic        bad;
      logic [3:0]  rm;
      logic [7:0]  amt;
      logic [31:0] off;
      logic [31:0] base;
      logic [31:0] addr;
      o   = '0;
      bad = 1'b0;
      amt = '0;
      off = '0;
      rm  = t.offset_field[3:0];
      case (t.command)
        CMD_WRITE_REG: regs[t.reg_index] = t.value;
        CMD_LOAD_RET: if (!load_drop) regs[load_dest] = t.value;
        CMD_EXECUTE: begin
          if (t.immediate_form) begin
            if (!t.pre_index && t.base_reg == rm) bad = 1'b1;
            else if (!t.offset_field[4]) amt = {3'b000, t.offset_field[11:7]};
            else if (t.offset_field[7] || t.offset_field[11:8] == REG_PC) bad = 1'b1;
            else amt = regs[t.offset_field[11:8]][7:0];
            off = shift_offset(regs[rm], t.offset_field[6:5], amt);
          end else begin
            off = {20'd0, t.offset_field};
          end
          if (bad) begin
            o.status = ST_INVALID;
          end else begin
            base = regs[t.base_reg];
            addr = base;
            if (t.pre_index) addr = t.add_offset ? base + off : base - off;
            o.address = addr;
            if (addr >= mem_size && (addr < dev_lo || addr > dev_hi)) begin
              o.status = ST_ILLEGAL;
            end else begin
              o.status        = ST_OK;
              o.request_valid = 1'b1;
              if (t.is_load) begin
                o.request_is_load = 1'b1;
                load_dest = t.data_reg;
                load_drop = !t.pre_index && t.data_reg == t.base_reg;
              end else begin
                o.store_data = regs[t.data_reg];
              end
              if (!t.pre_index) regs[t.base_reg] = t.add_offset ? addr + off : addr - off;
            end
          end
        end
        default: o.status = ST_INVALID;
      endcase
      return o;
    endfunction

    function void note_input(lsau_in_t t);
      expected_results.push_back(predict_transfer(t));
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("ERROR: %s", msg);
    endtask

    task check_result(lsau_out_t got);
      lsau_out_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result %h arrived with nothing expected", got));
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.request_valid !== want.request_valid)
        report($sformatf("request_valid got %b want %b", got.request_valid,
                         want.request_valid));
      if (got.request_is_load !== want.request_is_load)
        report($sformatf("request_is_load got %b want %b", got.request_is_load,
                         want.request_is_load));
      if (got.address !== want.address)
        report($sformatf("address got %h want %h", got.address, want.address));
      if (got.store_data !== want.store_data)
        report($sformatf("store_data got %h want %h", got.store_data, want.store_data));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  lsau_in_t    in_data   = '0;
  logic        out_stall = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = CFG_MEM_SIZE;
  logic [31:0] cfg_data  = '0;
  logic        in_stall;
  logic        out_valid;
  lsau_out_t   out_data;

  logic        idle_on = 1'b1;   // random gaps and stalls enabled
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  transfer_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  load_store_address_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Result side: check every accepted result, then pick the stall for the next
  // cycle. Stalls come in bursts; drop them entirely once idling is off.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_result(out_data);
    if (!idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("load_store_address_unit: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic lsau_in_t wr(logic [3:0] idx, logic [31:0] val);
    lsau_in_t t;
    t = '0;
    t.command   = CMD_WRITE_REG;
    t.reg_index = idx;
    t.value     = val;
    return t;
  endfunction

  function automatic lsau_in_t lr(logic [31:0] val);
    lsau_in_t t;
    t = '0;
    t.command = CMD_LOAD_RET;
    t.value   = val;
    return t;
  endfunction

  function automatic lsau_in_t ex(logic shifted, logic pre, logic add, logic load,
                                  logic [3:0] rn, logic [3:0] rd, logic [11:0] field);
    lsau_in_t t;
    t = '0;
    t.command        = CMD_EXECUTE;
    t.immediate_form = shifted;
    t.pre_index      = pre;
    t.add_offset     = add;
    t.is_load        = load;
    t.base_reg       = rn;
    t.data_reg       = rd;
    t.offset_field   = field;
    return t;
  endfunction

  // Offset register shifted by an immediate amount
  function automatic logic [11:0] shf_imm(logic [4:0] amt, logic [1:0] kind, logic [3:0] rm);
    return {amt, kind, 1'b0, rm};
  endfunction

  // Offset register shifted by the low byte of register rs
  function automatic logic [11:0] shf_reg(logic [3:0] rs, logic [1:0] kind, logic [3:0] rm);
    return {rs, 1'b0, kind, 1'b1, rm};
  endfunction

  // Register values: mostly inside small memory, some full range, some near
  // the device window, some small enough to be shift amounts.
  function automatic logic [31:0] rand_reg_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom_range(0, 32'hFFFF);
      2: return $urandom;
      3: return sb.dev_lo + $urandom_range(0, 48) - 32'd8;
      4: return $urandom_range(0, 70);
      default: return $urandom_range(0, 32'hFFF);
    endcase
  endfunction

  function automatic lsau_in_t rand_item();
    lsau_in_t    t;
    logic [31:0] r;
    int unsigned pick;
    r = $urandom;
    t.immediate_form = r[0];
    t.pre_index      = r[1];
    t.add_offset     = r[2];
    t.is_load        = r[3];
    t.base_reg       = r[7:4];
    t.data_reg       = r[11:8];
    t.reg_index      = r[15:12];
    t.offset_field   = r[27:16];
    t.value          = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      t.command = CMD_WRITE_REG;
      t.value   = rand_reg_value();
    end else if (pick < 80) begin
      t.command = CMD_EXECUTE;
      if (t.immediate_form) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
          t.offset_field[4] = 1'b0;
        end else if (pick < 18) begin
          t.offset_field[4] = 1'b1;
          t.offset_field[7] = 1'b0;
          // Keep shifts by the program counter register rare
          if (t.offset_field[11:8] == REG_PC && $urandom_range(0, 3) != 0)
            t.offset_field[11:8] = 4'($urandom_range(0, 14));
        end
      end
    end else if (pick < 95) begin
      t.command = CMD_LOAD_RET;
    end else begin
      t.command = CMD_UNUSED;
    end
    return t;
  endfunction

  // Present one transaction, optionally after an idle gap, and hold it until
  // accepted. Leave valid high afterwards so back-to-back items stay glitch-free.
  task automatic send_item(lsau_in_t t);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_input(t);
  endtask

  // Pause the sender until every expected result is back, then let the
  // pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic program_window(logic [31:0] ms, logic [31:0] lo, logic [31:0] hi);
    logic [1:0]  idx [3];
    logic [31:0] val [3];
    idx = '{CFG_MEM_SIZE, CFG_DEV_LOW, CFG_DEV_HIGH};
    val = '{ms, lo, hi};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.set_limit(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    lsau_in_t    item;
    logic        want_return;
    logic [31:0] lo;
    want_return = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: operand extremes, each shift type, saturating shifts,
    // post-index writeback, dropped load, invalid forms, window edges.
    send_item(wr(4'd1, 32'h8000_0001));
    send_item(wr(4'd2, 32'h0000_1000));
    send_item(wr(4'd3, 32'd40));
    send_item(wr(4'd4, 32'hFFFF_FFFF));
    send_item(ex(1'b0, 1'b1, 1'b1, 1'b1, 4'd2, 4'd5, 12'hFFF));
    send_item(lr(32'hDEAD_BEEF));
    send_item(ex(1'b0, 1'b1, 1'b0, 1'b0, 4'd2, 4'd5, 12'h000));
    send_item(ex(1'b1, 1'b1, 1'b1, 1'b0, 4'd2, 4'd4, shf_imm(5'd0, SH_LSL, 4'd2)));
    send_item(ex(1'b1, 1'b1, 1'b1, 1'b0, 4'd2, 4'd1, shf_reg(4'd3, SH_LSR, 4'd1)));
    send_item(ex(1'b1, 1'b1, 1'b1, 1'b1, 4'd2, 4'd7, shf_reg(4'd3, SH_ASR, 4'd1)));
    send_item(ex(1'b1, 1'b1, 1'b1, 1'b0, 4'd2, 4'd3, shf_imm(5'd31, SH_ROR, 4'd1)));
    send_item(ex(1'b1, 1'b1, 1'b0, 1'b0, 4'd0, 4'd3, shf_reg(4'd3, SH_ROR, 4'd1)));
    send_item(ex(1'b1, 1'b1, 1'b1, 1'b0, 4'd2, 4'd3, shf_imm(5'd31, SH_LSL, 4'd1)));
    // Post-indexed load into its own base: writeback wins over load data
    send_item(ex(1'b0, 1'b0, 1'b1, 1'b1, 4'd2, 4'd2, 12'h010));
    send_item(lr(32'h1234_5678));
    send_item(ex(1'b1, 1'b0, 1'b1, 1'b0, 4'd2, 4'd1, shf_imm(5'd1, SH_LSL, 4'd2)));
    send_item(ex(1'b1, 1'b1, 1'b1, 1'b0, 4'd2, 4'd1, shf_reg(REG_PC, SH_LSL, 4'd1)));
    send_item(ex(1'b1, 1'b1, 1'b1, 1'b0, 4'd2, 4'd1, 12'h091));
    send_item(ex(1'b0, 1'b1, 1'b1, 1'b1, 4'd4, 4'd1, 12'h000));
    send_item(wr(4'd6, DEV_HIGH_RST));
    send_item(ex(1'b0, 1'b1, 1'b1, 1'b1, 4'd6, 4'd8, 12'h000));
    send_item(ex(1'b0, 1'b1, 1'b0, 1'b0, 4'd6, 4'd8, 12'h029));
    send_item(ex(1'b0, 1'b0, 1'b0, 1'b0, 4'd6, 4'd4, 12'h028));
    item = '0;
    item.command = CMD_UNUSED;
    send_item(item);

    // Random phases, each under its own memory and window setting
    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: program_window(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
          2: program_window(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
          3: program_window(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000);
          4: begin
            lo = $urandom;
            program_window($urandom_range(1, 32'h2_0000), lo, lo + $urandom_range(0, 255));
          end
          default: begin
            program_window(MEM_SIZE_RST, DEV_LOW_RST, DEV_HIGH_RST);
            idle_on = 1'b0;   // run the last part at full rate
          end
        endcase
      end
      for (int n = 0; n < PhaseItems; n++) begin
        // Follow most issued loads with their data return
        if (want_return && $urandom_range(0, 9) < 6) begin
          item = rand_item();
          item.command = CMD_LOAD_RET;
        end else begin
          item = rand_item();
        end
        want_return = item.command == CMD_EXECUTE && item.is_load;
        send_item(item);
      end
    end

    settle();
    if (sb.pending() != 0) sb.report("expected results never arrived");
    if (sb.errors == 0)
      $display("load_store_address_unit: match");
    else
      $display("load_store_address_unit: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
src/lsau_pkg.sv
src/lsau_ram.sv
src/load_store_address_unit.sv
dv/testbench.sv
